### rtl/dmc_pkg.sv
package dmc_pkg;

	localparam int DEF_NUM_SETS = 16;

	localparam int ADDR_W   = 32;
	localparam int WORD_W   = 32;
	localparam int TAG_W    = 26;
	localparam int TAG_LSB  = 6;
	localparam int SET_W    = 4;
	localparam int SET_LSB  = 2;
	localparam int OFFSET_W = 2;
	localparam int BYTE_W   = 8;
	localparam int OUT_W    = 3;

	// number of sets the 4-bit address index can reach
	localparam int MAX_SETS = 1 << SET_W;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [OUT_W-1:0] OUT_READ_HIT      = 3'd0;
	localparam logic [OUT_W-1:0] OUT_READ_CONFLICT = 3'd1;
	localparam logic [OUT_W-1:0] OUT_READ_COLD     = 3'd2;
	localparam logic [OUT_W-1:0] OUT_WRITE         = 3'd3;
	localparam logic [OUT_W-1:0] OUT_WRITE_EVICT   = 3'd4;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] write_word;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0]  outcome;
		logic [SET_W-1:0]  set_index;
		logic [TAG_W-1:0]  request_tag;
		logic [TAG_W-1:0]  line_tag;
		logic              line_was_valid;
		logic [BYTE_W-1:0] read_byte;
		logic [WORD_W-1:0] evicted_word;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

endpackage

### rtl/dmc_ctrl.sv
module dmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output dmc_pkg::cmd_t cmd
);
	import dmc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.update;
		end
	end

	assign busy = (state_q == ST_LOOK);
	assign done = done_q;

endmodule

### rtl/dmc_datapath.sv
module dmc_datapath #(
	parameter int NUM_SETS = dmc_pkg::DEF_NUM_SETS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dmc_pkg::cmd_t cmd,
	input  dmc_pkg::req_t req,
	output dmc_pkg::rsp_t rsp
);
	import dmc_pkg::*;

	// only sixteen sets are reachable from the address index
	localparam int LINES = (NUM_SETS < MAX_SETS) ? NUM_SETS : MAX_SETS;
	localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

	logic [IDX_W-1:0] set_map [MAX_SETS];

	for (genvar g = 0; g < MAX_SETS; g++) begin : g_set_map
		localparam int MAPPED = g % NUM_SETS;
		assign set_map[g] = IDX_W'(MAPPED);
	end

	logic [TAG_W-1:0]  tag_mem  [LINES];
	logic [WORD_W-1:0] data_mem [LINES];
	logic [LINES-1:0]  valid_q;

	logic [IDX_W-1:0]  idx_in;
	req_t              req_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [TAG_W-1:0]  rd_tag_s1;
	logic [WORD_W-1:0] rd_data_s1;
	logic              vld_s1;
	rsp_t              rsp_q;

	assign idx_in = set_map[req.address[SET_LSB +: SET_W]];

	// request capture, registered array read and array write on update
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1     <= req;
			idx_s1     <= idx_in;
			rd_tag_s1  <= tag_mem[idx_in];
			rd_data_s1 <= data_mem[idx_in];
		end
		if (cmd.update && req_s1.func == FUNC_WRITE) begin
			tag_mem[idx_s1]  <= req_s1.address[TAG_LSB +: TAG_W];
			data_mem[idx_s1] <= req_s1.write_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				vld_s1 <= valid_q[idx_in];
			end
			if (cmd.update && req_s1.func == FUNC_WRITE) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	logic [TAG_W-1:0]    req_tag;
	logic [TAG_W-1:0]    old_tag;
	logic [WORD_W-1:0]   old_word;
	logic [OFFSET_W-1:0] offset;
	logic                tag_eq;
	rsp_t                rsp_d;

	always_comb begin
		req_tag  = req_s1.address[TAG_LSB +: TAG_W];
		offset   = req_s1.address[OFFSET_W-1:0];
		old_tag  = vld_s1 ? rd_tag_s1 : '0;
		old_word = vld_s1 ? rd_data_s1 : '0;
		tag_eq   = (old_tag == req_tag);

		rsp_d.set_index      = SET_W'(idx_s1);
		rsp_d.request_tag    = req_tag;
		rsp_d.line_tag       = old_tag;
		rsp_d.line_was_valid = vld_s1;
		rsp_d.read_byte      = '0;
		rsp_d.evicted_word   = '0;

		if (req_s1.func == FUNC_WRITE) begin
			if (vld_s1 && !tag_eq) begin
				rsp_d.outcome      = OUT_WRITE_EVICT;
				rsp_d.evicted_word = old_word;
			end else begin
				rsp_d.outcome = OUT_WRITE;
			end
		end else if (vld_s1) begin
			rsp_d.read_byte = old_word[{offset, 3'b000} +: BYTE_W];
			rsp_d.outcome   = tag_eq ? OUT_READ_HIT : OUT_READ_CONFLICT;
		end else begin
			rsp_d.outcome = OUT_READ_COLD;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/direct_mapped_cache_lookup_core.sv
// direct-mapped cache lookup, one line of four bytes per set
//
// request channel: present req with start high; the transfer happens at the
// rising edge where start is high and busy is low. busy is high while the
// registered line read is compared and the line is updated.
// result channel: rsp is valid for exactly one cycle, marked by done, in the
// cycle after the lookup. the receiver cannot stall, so every result is
// taken in the cycle it is shown.
// request rate: no new request transfers while busy is high, since the
// registered read of the tag and data arrays comes ahead of the compare and
// write-back. a new request may transfer in the cycle done is high.
// reset: arst_n low clears every valid bit and the controller at once, so
// all lines read as cold misses; tag and data arrays are not cleared.
// only sixteen sets are addressable, so at most sixteen lines are built.
module direct_mapped_cache_lookup_core #(
	parameter int NUM_SETS = dmc_pkg::DEF_NUM_SETS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dmc_pkg::req_t req,
	output logic          done,
	output dmc_pkg::rsp_t rsp
);
	import dmc_pkg::*;

	// command bundle from the sequencer
	cmd_t cmd;

	// two-state sequencer: idle and lookup
	dmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// arrays, compare and result register
	dmc_datapath #(
		.NUM_SETS (NUM_SETS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### rtl/dmc_checker.sv
module dmc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dmc_pkg::rsp_t rsp
);
	import dmc_pkg::*;

	// an accepted request makes the block busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer not followed by busy");

	// each lookup cycle produces exactly one result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("lookup not followed by a result");

	// results only come out of a lookup
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a lookup");

	// hit, conflict or write eviction needs a valid line
	a_outcome_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((rsp.outcome == OUT_READ_HIT || rsp.outcome == OUT_READ_CONFLICT
			|| rsp.outcome == OUT_WRITE_EVICT) && rsp.line_was_valid)
			|| rsp.outcome == OUT_READ_COLD || rsp.outcome == OUT_WRITE))
		else $error("outcome inconsistent with line valid");

endmodule

bind direct_mapped_cache_lookup_core dmc_checker u_dmc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### sim/direct_mapped_cache_lookup_core_tb.sv
module direct_mapped_cache_lookup_core_tb;
	import dmc_pkg::*;

	localparam int SETS        = DEF_NUM_SETS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;
	localparam int RANDOM_OPS  = 450;
	localparam int IDLE_PCT    = 35;

	typedef struct {
		req_t req;
		bit   wait_empty; // hold the transfer until every result is back
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	direct_mapped_cache_lookup_core #(
		.NUM_SETS(SETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// cache image kept by the checker
	bit              line_ok  [SETS];
	bit [TAG_W-1:0]  line_tag [SETS];
	bit [WORD_W-1:0] line_word[SETS];

	access_t access_queue[$];
	rsp_t    due_results[$];
	int      issued = 0;
	int      accepted = 0;
	int      cycles = 0;
	int      errors = 0;
	bit [TAG_W-1:0] hot_tags[4];
	access_t next_access;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic rsp_t predict_access(req_t r);
		rsp_t                o;
		int                  s;
		logic [TAG_W-1:0]    t;
		logic [OFFSET_W-1:0] off;
		s   = int'(r.address[SET_LSB +: SET_W]) % SETS;
		t   = r.address[TAG_LSB +: TAG_W];
		off = r.address[OFFSET_W-1:0];
		o = '0;
		o.set_index      = SET_W'(s);
		o.request_tag    = t;
		o.line_was_valid = line_ok[s];
		if (line_ok[s])
			o.line_tag = line_tag[s];
		if (r.func == FUNC_WRITE) begin
			if (line_ok[s] && line_tag[s] != t) begin
				o.outcome      = OUT_WRITE_EVICT;
				o.evicted_word = line_word[s];
			end else begin
				o.outcome = OUT_WRITE;
			end
			line_ok[s]   = 1'b1;
			line_tag[s]  = t;
			line_word[s] = r.write_word;
		end else if (line_ok[s]) begin
			o.read_byte = line_word[s][off*BYTE_W +: BYTE_W];
			o.outcome   = (line_tag[s] == t) ? OUT_READ_HIT : OUT_READ_CONFLICT;
		end else begin
			o.outcome = OUT_READ_COLD;
		end
		return o;
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] t, int s, int off);
		return {t, SET_W'(s), OFFSET_W'(off)};
	endfunction

	task automatic queue_access(logic f, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] w,
				    bit hold = 1'b0);
		access_t x;
		x.req.func       = f;
		x.req.address    = a;
		x.req.write_word = w;
		x.wait_empty     = hold;
		access_queue.push_back(x);
	endtask

	// driver: new request or idle at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && issued != accepted) begin
				// request still waiting for its transfer
			end else if (access_queue.size() != 0
				     && !(access_queue[0].wait_empty && due_results.size() != 0)
				     && ((issued >= 200 && issued < 300)
					 || $urandom_range(99) >= IDLE_PCT)) begin
				next_access = access_queue.pop_front();
				start <= 1'b1;
				req   <= next_access.req;
				issued++;
			end else begin
				start <= 1'b0;
				// junk on the bus while idle
				req   <= req_t'({1'($urandom), $urandom, $urandom});
			end
		end
	end

	// monitor: results and request transfers at the rising edge
	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					rsp_t e;
					e = due_results.pop_front();
					compare_field("outcome", 32'(e.outcome), 32'(rsp.outcome));
					compare_field("set_index", 32'(e.set_index), 32'(rsp.set_index));
					compare_field("request_tag", 32'(e.request_tag),
						      32'(rsp.request_tag));
					compare_field("line_tag", 32'(e.line_tag), 32'(rsp.line_tag));
					compare_field("line_was_valid", 32'(e.line_was_valid),
						      32'(rsp.line_was_valid));
					compare_field("read_byte", 32'(e.read_byte), 32'(rsp.read_byte));
					compare_field("evicted_word", e.evicted_word, rsp.evicted_word);
				end
			end
			if (start && !busy) begin
				due_results.push_back(predict_access(req));
				accepted++;
			end
		end
	end

	initial begin
		logic [TAG_W-1:0] t;
		int               s;
		logic             f;
		foreach (hot_tags[i])
			hot_tags[i] = TAG_W'($urandom);

		// cold misses straight after reset
		queue_access(FUNC_READ, 32'h0000_0000, 32'h0);
		queue_access(FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// fill, then every byte offset hits
		queue_access(FUNC_WRITE, 32'h0000_0000, 32'h0403_0201);
		for (int o = 0; o < 4; o++)
			queue_access(FUNC_READ, make_addr('0, 0, o), 32'h0);
		queue_access(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_access(FUNC_READ, 32'hFFFF_FFFC, 32'h0);
		queue_access(FUNC_READ, 32'hFFFF_FFFF, 32'h0);
		// conflict miss still returns the stored byte
		queue_access(FUNC_READ, make_addr('1, 0, 2), 32'h0);
		queue_access(FUNC_READ, make_addr('0, 15, 1), 32'h0);
		// rewrite with the same tag: no eviction
		queue_access(FUNC_WRITE, make_addr('0, 0, 3), 32'hA5A5_5A5A);
		queue_access(FUNC_READ, make_addr('0, 0, 3), 32'h0);
		// other tag replaces the line
		queue_access(FUNC_WRITE, make_addr('1, 0, 0), 32'h1234_5678);
		queue_access(FUNC_WRITE, make_addr('0, 15, 0), 32'h0000_0000);
		queue_access(FUNC_READ, make_addr('1, 0, 1), 32'h0);
		queue_access(FUNC_READ, make_addr('0, 15, 3), 32'h0);
		queue_access(FUNC_READ, make_addr('1, 7, 0), 32'h0);
		queue_access(FUNC_WRITE, make_addr(26'h2AA_AAAA, 7, 2), 32'h8000_0001, 1'b1);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			f = ($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_READ;
			if ($urandom_range(99) < 75) begin
				// small tag pool so hits, conflicts and evictions recur
				t = hot_tags[$urandom_range(3)];
				s = $urandom_range(SETS - 1);
				queue_access(f, make_addr(t, s, $urandom_range(3)), $urandom,
					     n == 150 || n == 350);
			end else begin
				queue_access(f, $urandom, $urandom, n == 150 || n == 350);
			end
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (!(access_queue.size() == 0 && issued == accepted && due_results.size() == 0)
		       && cycles < CYCLE_LIMIT)
			@(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("direct_mapped_cache_lookup_core: mismatch");
		end else begin
			repeat (DRAIN_WAIT) @(posedge clk);
			if (errors == 0 && due_results.size() == 0)
				$display("direct_mapped_cache_lookup_core: match");
			else
				$display("direct_mapped_cache_lookup_core: mismatch");
		end
		$finish;
	end

endmodule

### sim.f
rtl/dmc_pkg.sv
rtl/dmc_ctrl.sv
rtl/dmc_datapath.sv
rtl/direct_mapped_cache_lookup_core.sv
rtl/dmc_checker.sv
sim/direct_mapped_cache_lookup_core_tb.sv
